// File: hdl/hgtr_pkg.sv
// Package for the HTTP GET target router.
// Holds the phase and route codes, the request state types and the literal texts.
// Depends on nothing.
`default_nettype none

package hgtr_pkg;

  // Target limits: longest target read and longest decoded argument.
  localparam logic [7:0] TARGET_MAX  = 8'd191;
  localparam logic [7:0] DECODED_MAX = 8'd191;

  // Results one input word can cause.
  localparam int unsigned MAX_RESULTS = 4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT    = 8'h2e;

  // "GET ", "path=", "/fs", "/dl"
  localparam logic [7:0] METHOD_TEXT [4] = '{8'h47, 8'h45, 8'h54, 8'h20};
  localparam logic [7:0] KEY_TEXT    [5] = '{8'h70, 8'h61, 8'h74, 8'h68, 8'h3d};
  localparam logic [7:0] FS_TEXT     [3] = '{8'h2f, 8'h66, 8'h73};
  localparam logic [7:0] DL_TEXT     [3] = '{8'h2f, 8'h64, 8'h6c};

  typedef enum logic [6:0] {
    PH_METHOD = 7'b0000001,
    PH_PATH   = 7'b0000010,
    PH_KEY    = 7'b0000100,
    PH_SKIP   = 7'b0001000,
    PH_VALUE  = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_FAIL   = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    ROUTE_STATUS    = 2'd0,
    ROUTE_DIR       = 2'd1,
    ROUTE_FILE      = 2'd2,
    ROUTE_NOT_FOUND = 2'd3
  } route_e;

  localparam logic KIND_ARG     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Per-request state; route_match bit 0 "/", bit 1 "/fs", bit 2 "/dl".
  typedef struct packed {
    phase_e     phase;
    logic [2:0] method_index;
    logic [7:0] target_length;
    logic [2:0] route_match;
    logic [2:0] key_index;
    logic [1:0] escape_count;
    logic [7:0] escape_char;
    logic [7:0] arg_length;
    logic       arg_stopped;
    logic       unsafe;
    logic       prev_dot;
  } req_st_t;

  // Request state plus the argument bytes gathered for one input word.
  typedef struct packed {
    req_st_t         st;
    logic [2:0]      n_args;
    logic [3:0][7:0] args;
  } work_t;

  function automatic logic [4:0] hex_of(logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61) + 5'd10;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41) + 5'd10;
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/http_get_target_router_top.sv
// HTTP GET target router, top level.
// Parses the request line a word at a time and queues decoded argument bytes and the verdict.
// Depends on hgtr_pkg.
//
// Usage:
//   Input channel: one request byte per word (req_byte_i, final_byte_i), taken when
//   in_valid_i is high and in_stall_o is low. final_byte_i marks the last byte of a request.
//   Output channel: result words (item_kind_o and the verdict fields), taken when
//   out_valid_o is high and out_stall_i is low. Argument words carry item_kind_o = 0;
//   the verdict carries item_kind_o = 1 and end_of_run_o = 1.
// Latency: a result word appears on the cycle after the byte that causes it.
// Throughput: one byte per cycle while each byte causes at most one result and out_stall_i is
//   low. A byte that causes k results (an escape flush, or a flush plus the verdict, k up to
//   4) holds in_stall_o until its last result is taken; words drain one a cycle when unstalled.
// Stall: while out_stall_i is high the current result word holds; once the queued results
//   of the last byte are all but one gone, in_stall_o follows out_stall_i.
// Reset: rst_ni clears the parse state, the result queue and the served count; the block
//   is ready for a new request on the first cycle after reset.
`default_nettype none

module http_get_target_router_top
  import hgtr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  req_byte_i,
  input  wire logic        final_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             item_kind_o,
  output logic [7:0]       arg_byte_o,
  output logic [1:0]       route_o,
  output logic             used_root_default_o,
  output logic [31:0]      served_count_o,
  output logic             end_of_run_o
);

  function automatic req_st_t clear_st();
    req_st_t s;
    s.phase         = PH_METHOD;
    s.method_index  = 3'd0;
    s.target_length = 8'd0;
    s.route_match   = 3'b111;
    s.key_index     = 3'd0;
    s.escape_count  = 2'd0;
    s.escape_char   = 8'd0;
    s.arg_length    = 8'd0;
    s.arg_stopped   = 1'b0;
    s.unsafe        = 1'b0;
    s.prev_dot      = 1'b0;
    return s;
  endfunction

  function automatic work_t arg_emit(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    if (!r.st.arg_stopped) begin
      if (b == CH_AMP || b == CH_NUL) begin
        r.st.arg_stopped = 1'b1;
      end else begin
        if (r.st.arg_length == 8'd0 && b != CH_SLASH) r.st.unsafe = 1'b1;
        if (b == CH_BSLASH || b < CH_SPACE) r.st.unsafe = 1'b1;
        if (b == CH_DOT) begin
          if (r.st.prev_dot) r.st.unsafe = 1'b1;
          r.st.prev_dot = 1'b1;
        end else begin
          r.st.prev_dot = 1'b0;
        end
        // drop bytes beyond the result slots, but still count them
        if (r.n_args < 3'(MAX_RESULTS)) begin
          r.args[r.n_args[1:0]] = b;
          r.n_args = r.n_args + 3'd1;
        end
        r.st.arg_length = r.st.arg_length + 8'd1;
        if (r.st.arg_length >= DECODED_MAX) r.st.arg_stopped = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic work_t decode_plain(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (c == CH_PCT) begin
      r.st.escape_count = 2'd1;
    end else begin
      r = arg_emit(r, (c == CH_PLUS) ? CH_SPACE : c);
    end
    return r;
  endfunction

  function automatic work_t decode_byte(work_t w, logic [7:0] c);
    work_t      r;
    logic [4:0] hc;
    logic [4:0] he;
    r  = w;
    hc = hex_of(c);
    he = hex_of(r.st.escape_char);
    if (r.st.escape_count == 2'd1) begin
      if (!hc[4]) begin
        r.st.escape_char  = c;
        r.st.escape_count = 2'd2;
      end else begin
        r.st.escape_count = 2'd0;
        r = arg_emit(r, CH_PCT);
        r = decode_plain(r, c);
      end
    end else if (r.st.escape_count == 2'd2) begin
      r.st.escape_count = 2'd0;
      if (!hc[4]) begin
        r = arg_emit(r, {he[3:0], hc[3:0]});
      end else begin
        r = arg_emit(r, CH_PCT);
        r = arg_emit(r, r.st.escape_char);
        r = decode_plain(r, c);
      end
    end else begin
      r = decode_plain(r, c);
    end
    return r;
  endfunction

  // Keep a route candidate only if the path length matches it exactly.
  function automatic req_st_t resolve_path(req_st_t s);
    req_st_t r;
    r = s;
    if (r.target_length != 8'd1) r.route_match[0] = 1'b0;
    if (r.target_length != 8'd3) r.route_match[2:1] = 2'b00;
    return r;
  endfunction

  function automatic work_t end_target(work_t w);
    work_t r;
    r = w;
    if (r.st.phase == PH_PATH) r.st = resolve_path(r.st);
    if (r.st.phase == PH_VALUE) begin
      // flush an open escape literally
      if (r.st.escape_count != 2'd0) r = arg_emit(r, CH_PCT);
      if (r.st.escape_count == 2'd2) r = arg_emit(r, r.st.escape_char);
      r.st.escape_count = 2'd0;
    end
    r.st.phase = PH_DONE;
    return r;
  endfunction

  function automatic req_st_t path_byte(req_st_t s, logic [7:0] c);
    req_st_t r;
    logic    short_pos;
    r = s;
    short_pos = (r.target_length < 8'd3);
    if (c == CH_QMARK) begin
      r = resolve_path(r);
      r.phase     = PH_KEY;
      r.key_index = 3'd0;
    end else begin
      if (!(r.target_length == 8'd0 && c == CH_SLASH)) r.route_match[0] = 1'b0;
      if (!short_pos || FS_TEXT[r.target_length[1:0]] != c) r.route_match[1] = 1'b0;
      if (!short_pos || DL_TEXT[r.target_length[1:0]] != c) r.route_match[2] = 1'b0;
    end
    return r;
  endfunction

  function automatic work_t target_byte(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_NUL) begin
      r = end_target(r);
    end else begin
      if (r.st.phase == PH_PATH) begin
        r.st = path_byte(r.st, c);
      end else if (r.st.phase == PH_KEY) begin
        if (r.st.key_index < 3'd5 && c == KEY_TEXT[r.st.key_index]) begin
          r.st.key_index = r.st.key_index + 3'd1;
          if (r.st.key_index == 3'd5) r.st.phase = PH_VALUE;
        end else if (c != CH_AMP) begin
          r.st.phase = PH_SKIP;
        end else begin
          r.st.key_index = 3'd0;
        end
      end else if (r.st.phase == PH_SKIP) begin
        if (c == CH_AMP) begin
          r.st.phase     = PH_KEY;
          r.st.key_index = 3'd0;
        end
      end else begin
        r = decode_byte(r, c);
      end
      r.st.target_length = r.st.target_length + 8'd1;
      if (r.st.target_length >= TARGET_MAX) r = end_target(r);
    end
    return r;
  endfunction

  function automatic logic in_target(phase_e p);
    return p == PH_PATH || p == PH_KEY || p == PH_SKIP || p == PH_VALUE;
  endfunction

  // Parse state and served count
  req_st_t     st_q, st_d;
  logic [31:0] count_q, count_d;

  // Result queue for the last accepted word
  logic [3:0][7:0] bat_args_q;
  logic [2:0]      bat_nargs_q;
  logic            bat_verdict_q;
  logic [2:0]      bat_idx_q;
  route_e          bat_route_q;
  logic            bat_root_q;
  logic [31:0]     bat_count_q;

  work_t      w;
  logic       in_fire;
  logic       out_fire;
  logic [2:0] bat_total;
  logic       bat_draining;
  logic       counted;
  logic       vrd_present;
  route_e     vrd_route;
  logic       vrd_root;
  logic       is_verdict;

  assign bat_total    = bat_nargs_q + {2'b00, bat_verdict_q};
  assign out_valid_o  = (bat_idx_q != bat_total);
  assign out_fire     = out_valid_o && !out_stall_i;
  assign bat_draining = !out_valid_o || (out_fire && (bat_idx_q + 3'd1 == bat_total));
  assign in_stall_o   = !bat_draining;
  assign in_fire      = in_valid_i && !in_stall_o;

  always_comb begin
    w.st     = st_q;
    w.n_args = 3'd0;
    w.args   = '0;
    count_d  = count_q;
    counted  = 1'b0;
    vrd_route = ROUTE_NOT_FOUND;
    vrd_root  = 1'b0;
    vrd_present = 1'b0;

    if (w.st.phase == PH_METHOD) begin
      if (w.st.method_index < 3'd4 && req_byte_i == METHOD_TEXT[w.st.method_index[1:0]]) begin
        w.st.method_index = w.st.method_index + 3'd1;
        if (w.st.method_index == 3'd4) begin
          w.st.phase         = PH_PATH;
          w.st.target_length = 8'd0;
        end
      end else begin
        w.st.phase = PH_FAIL;
      end
    end else if (in_target(w.st.phase)) begin
      w = target_byte(w, req_byte_i);
    end

    if (final_byte_i) begin
      if (in_target(w.st.phase)) w = end_target(w);
      counted = (w.st.phase == PH_DONE) && (w.st.target_length != 8'd0);
      if (counted) begin
        count_d = count_q + 32'd1;
        if (w.st.route_match[0]) begin
          vrd_route = ROUTE_STATUS;
        end else if (w.st.route_match[1]) begin
          if (w.st.arg_length == 8'd0) begin
            vrd_route = ROUTE_DIR;
            vrd_root  = 1'b1;
          end else if (!w.st.unsafe) begin
            vrd_route = ROUTE_DIR;
          end
        end else if (w.st.route_match[2]) begin
          if (w.st.arg_length != 8'd0 && !w.st.unsafe) vrd_route = ROUTE_FILE;
        end
      end
      // the verdict takes a slot only if one is left
      vrd_present = (w.n_args < 3'(MAX_RESULTS));
      st_d = clear_st();
    end else begin
      st_d = w.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= clear_st();
      count_q       <= 32'd0;
      bat_nargs_q   <= 3'd0;
      bat_verdict_q <= 1'b0;
      bat_idx_q     <= 3'd0;
    end else if (in_fire) begin
      st_q          <= st_d;
      count_q       <= count_d;
      bat_nargs_q   <= w.n_args;
      bat_verdict_q <= vrd_present;
      bat_idx_q     <= 3'd0;
    end else if (out_fire) begin
      bat_idx_q <= bat_idx_q + 3'd1;
    end
  end

  // Payload of the queue: no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bat_args_q  <= w.args;
      bat_route_q <= vrd_route;
      bat_root_q  <= vrd_root;
      bat_count_q <= count_d;
    end
  end

  assign is_verdict          = bat_verdict_q && (bat_idx_q == bat_nargs_q);
  assign item_kind_o         = is_verdict ? KIND_VERDICT : KIND_ARG;
  assign arg_byte_o          = is_verdict ? 8'd0 : bat_args_q[bat_idx_q[1:0]];
  assign route_o             = is_verdict ? bat_route_q : ROUTE_STATUS;
  assign used_root_default_o = is_verdict && bat_root_q;
  assign served_count_o      = is_verdict ? bat_count_q : 32'd0;
  assign end_of_run_o        = is_verdict;

endmodule

`default_nettype wire
